// ===== src/vbb_pkg.sv =====
// Shared types and constants for the clamped 3x3x3 volume box blur.
package vbb_pkg;

	localparam int MAX_DIM  = 32;
	localparam int COORD_W  = $clog2(MAX_DIM);
	localparam int SIZE_W   = 6;
	localparam int ADDR_W   = 3 * COORD_W;
	localparam int SAMPLE_W = 16;
	localparam int TAPS     = 27;
	localparam int SUM_W    = SAMPLE_W + $clog2(TAPS);

	// floor(s / 27) == floor(s * DIV_MULT / 2^DIV_SHIFT) for every s below 2^SUM_W
	localparam int DIV_SHIFT = SUM_W + $clog2(TAPS);
	localparam int MULT_W    = 22;
	localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'((64'd1 << DIV_SHIFT) / TAPS + 1);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef struct packed {
		logic                func;
		logic [COORD_W-1:0]  pos_x;
		logic [COORD_W-1:0]  pos_y;
		logic [COORD_W-1:0]  pos_z;
		logic [SAMPLE_W-1:0] sample_in;
	} item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] blurred;
		logic                out_of_range;
	} result_t;

endpackage

// ===== src/vbb_div27.sv =====
// Divide-by-27 unit: reciprocal multiply split into two partial products, three stages.
module vbb_div27 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [vbb_pkg::SUM_W-1:0]     sum,
	output logic                          done,
	output logic [vbb_pkg::SAMPLE_W-1:0]  quotient
);
	import vbb_pkg::*;

	localparam int LO_W  = 11;
	localparam int HI_W  = SUM_W - LO_W;
	localparam int PLO_W = LO_W + MULT_W;
	localparam int PHI_W = HI_W + MULT_W;
	localparam int TOT_W = PHI_W + LO_W + 1;

	logic              vld_s1, vld_s2, vld_s3;
	logic [PLO_W-1:0]  prod_lo_s1, prod_lo_s2;
	logic [HI_W-1:0]   sum_hi_s1;
	logic [PHI_W-1:0]  prod_hi_s2;
	logic [SAMPLE_W-1:0] quo_s3;
	logic [TOT_W-1:0]  total;

	assign total = {1'b0, prod_hi_s2, {LO_W{1'b0}}} + TOT_W'(prod_lo_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_lo_s1 <= PLO_W'(sum[LO_W-1:0]) * PLO_W'(DIV_MULT);
		sum_hi_s1  <= sum[SUM_W-1:LO_W];
		prod_lo_s2 <= prod_lo_s1;
		prod_hi_s2 <= PHI_W'(sum_hi_s1) * PHI_W'(DIV_MULT);
		quo_s3     <= total[DIV_SHIFT +: SAMPLE_W];
	end

	assign done     = vld_s3;
	assign quotient = quo_s3;

endmodule

// ===== src/volume_box_blur_clamped_top.sv =====
// Top level: voxel volume memory, 27-tap scan sequencer and result register.
//
// Channels: item (valid/ready) carries a write or a query, result (valid/ready)
// carries one transaction per query, cfg (valid/ready, always ready) writes
// size_x, size_y, size_z by index 0..2; other indexes are ignored.
// A write is taken and the block stays ready for the next item.
// A query inside the grid reads its 27 clamped neighbors from the single-port
// volume memory, one per cycle, then goes through the three-stage divide by 27;
// the next item is taken once the result is loaded into the output register.
// A query outside the grid answers with out_of_range set and blurred zero.
// The single memory port sets the query rate.
// If the receiver stalls, the finished result waits in the output register and
// the block takes a new item; a second finished query waits until the first
// result is taken.
// Reset sets all sizes to 32 and empties the result register; the volume
// memory is not cleared and every voxel must be written before it is read.
module volume_box_blur_clamped_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  vbb_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output vbb_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [vbb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vbb_pkg::SIZE_W-1:0]     cfg_data
);
	import vbb_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_WAIT  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	localparam logic [1:0] OFS_LO  = 2'd0;
	localparam logic [1:0] OFS_MID = 2'd1;
	localparam logic [1:0] OFS_HI  = 2'd2;

	function automatic logic [COORD_W-1:0] nb_coord(
		input logic [COORD_W-1:0] p,
		input logic [1:0]         d,
		input logic [SIZE_W-1:0]  n
	);
		logic [SIZE_W-1:0] up;
		logic [SIZE_W-1:0] top;
		begin
			up  = {1'b0, p} + SIZE_W'(1);
			top = n - SIZE_W'(1);
			case (d)
				OFS_LO:  nb_coord = (p == '0) ? '0 : p - COORD_W'(1);
				OFS_MID: nb_coord = p;
				OFS_HI:  nb_coord = (up >= n) ? top[COORD_W-1:0] : up[COORD_W-1:0];
				default: nb_coord = p;
			endcase
		end
	endfunction

	logic [SIZE_W-1:0]   size_x_q, size_y_q, size_z_q;
	logic [SIZE_W-1:0]   nx, ny, nz;
	logic [2:0]          state_q;
	logic [COORD_W-1:0]  qx_q, qy_q, qz_q;
	logic [1:0]          ofs_x_q, ofs_y_q, ofs_z_q;
	logic                last_tap;
	logic                in_grid;
	logic                item_fire;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_addr;
	logic [SAMPLE_W-1:0] mem [2**ADDR_W];
	logic [SAMPLE_W-1:0] rd_s1;
	logic                rd_vld_s1;
	logic [SUM_W-1:0]    sum_q;
	logic                div_done;
	logic [SAMPLE_W-1:0] div_quo;
	logic [SAMPLE_W-1:0] res_val_q;
	logic                res_oor_q;
	result_t             out_q;
	logic                out_vld_q;

	assign cfg_ready = 1'b1;

	assign nx = (size_x_q > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : size_x_q;
	assign ny = (size_y_q > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : size_y_q;
	assign nz = (size_z_q > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : size_z_q;

	assign in_grid = ({1'b0, item.pos_x} < nx) && ({1'b0, item.pos_y} < ny) &&
		({1'b0, item.pos_z} < nz);

	assign item_ready = (state_q == ST_IDLE);
	assign item_fire  = item_valid && item_ready;
	assign mem_we     = item_fire && (item.func == FUNC_WRITE) && in_grid;
	assign last_tap   = (ofs_x_q == OFS_HI) && (ofs_y_q == OFS_HI) && (ofs_z_q == OFS_HI);

	always_comb begin
		if (state_q == ST_IDLE) begin
			mem_addr = {item.pos_z, item.pos_y, item.pos_x};
		end else begin
			mem_addr = {nb_coord(qz_q, ofs_z_q, nz), nb_coord(qy_q, ofs_y_q, ny),
				nb_coord(qx_q, ofs_x_q, nx)};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= item.sample_in;
		end
		rd_s1 <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_W'(MAX_DIM);
			size_y_q <= SIZE_W'(MAX_DIM);
			size_z_q <= SIZE_W'(MAX_DIM);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SIZE_X: size_x_q <= cfg_data;
				CFG_SIZE_Y: size_y_q <= cfg_data;
				CFG_SIZE_Z: size_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_vld_s1 <= 1'b0;
			ofs_x_q   <= OFS_LO;
			ofs_y_q   <= OFS_LO;
			ofs_z_q   <= OFS_LO;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			if ((state_q == ST_DONE) && (!out_vld_q || result_ready)) begin
				out_vld_q <= 1'b1;
			end else if (result_valid && result_ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_fire && (item.func == FUNC_QUERY)) begin
						ofs_x_q <= OFS_LO;
						ofs_y_q <= OFS_LO;
						ofs_z_q <= OFS_LO;
						state_q <= in_grid ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					if (ofs_x_q != OFS_HI) begin
						ofs_x_q <= ofs_x_q + 2'd1;
					end else begin
						ofs_x_q <= OFS_LO;
						if (ofs_y_q != OFS_HI) begin
							ofs_y_q <= ofs_y_q + 2'd1;
						end else begin
							ofs_y_q <= OFS_LO;
							ofs_z_q <= ofs_z_q + 2'd1;
						end
					end
					if (last_tap) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_DIV;
				ST_DIV:   state_q <= ST_WAIT;
				ST_WAIT: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_vld_q || result_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			qx_q      <= item.pos_x;
			qy_q      <= item.pos_y;
			qz_q      <= item.pos_z;
			sum_q     <= '0;
			res_val_q <= '0;
			res_oor_q <= !in_grid;
		end else if (rd_vld_s1) begin
			sum_q <= sum_q + SUM_W'(rd_s1);
		end
		if ((state_q == ST_WAIT) && div_done) begin
			res_val_q <= div_quo;
		end
		if ((state_q == ST_DONE) && (!out_vld_q || result_ready)) begin
			out_q.blurred      <= res_val_q;
			out_q.out_of_range <= res_oor_q;
		end
	end

	vbb_div27 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DIV),
		.sum      (sum_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign result_valid = out_vld_q;
	assign result       = out_q;

`ifndef SYNTH
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.out_of_range |-> result.blurred == '0)
		else $error("out-of-range result carries a nonzero value");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.func == FUNC_QUERY |=> !item_ready)
		else $error("ready after query transaction");

	a_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.func == FUNC_WRITE |=> item_ready)
		else $error("write transaction stalled the block");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_WAIT)
		else $error("divider finished outside wait state");

	a_rd_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("sample accumulated outside scan");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the clamped 3x3x3 volume box blur, with a built-in predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import vbb_pkg::*;

	localparam int VOXELS    = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE    = 40;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_ready;
	item_t                item = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_t              result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SIZE_W-1:0]    cfg_data = '0;

	// predictor state
	logic [SAMPLE_W-1:0] voxel_mem [VOXELS];
	bit                  voxel_filled [VOXELS];
	logic [SIZE_W-1:0]   size_x_reg = 6'd32;
	logic [SIZE_W-1:0]   size_y_reg = 6'd32;
	logic [SIZE_W-1:0]   size_z_reg = 6'd32;

	item_t   item_pending_q [$];
	result_t blur_expect_q [$];
	result_t want;
	int      mismatches = 0;
	int      items_planned = 0;

	int send_idle_pct = 10;
	int recv_idle_pct = 63;
	bit stall_go = 1'b0;
	bit stall_done = 1'b0;
	int hold_cnt = 0;

	volume_box_blur_clamped_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int eff_size(input logic [SIZE_W-1:0] r);
		return (int'(r) > MAX_DIM) ? MAX_DIM : int'(r);
	endfunction

	function automatic int vox_addr(input int x, input int y, input int z);
		return x + MAX_DIM * (y + MAX_DIM * z);
	endfunction

	function automatic int clamp_nb(input int p, input int d, input int n);
		if (d < 0)
			return (p == 0) ? 0 : p - 1;
		if (d > 0)
			return (p + 1 >= n) ? n - 1 : p + 1;
		return p;
	endfunction

	function automatic bit in_grid(input int x, input int y, input int z);
		return (x < eff_size(size_x_reg)) && (y < eff_size(size_y_reg)) &&
			(z < eff_size(size_z_reg));
	endfunction

	function automatic bit neighborhood_filled(input int x, input int y, input int z);
		int nx, ny, nz;
		nx = eff_size(size_x_reg);
		ny = eff_size(size_y_reg);
		nz = eff_size(size_z_reg);
		for (int c = -1; c <= 1; c++)
			for (int b = -1; b <= 1; b++)
				for (int a = -1; a <= 1; a++)
					if (!voxel_filled[vox_addr(clamp_nb(x, a, nx), clamp_nb(y, b, ny),
						clamp_nb(z, c, nz))])
						return 1'b0;
		return 1'b1;
	endfunction

	function automatic void predict_blur(input item_t it);
		int      nx, ny, nz, sum, px, py, pz;
		result_t r;
		nx = eff_size(size_x_reg);
		ny = eff_size(size_y_reg);
		nz = eff_size(size_z_reg);
		px = int'(it.pos_x);
		py = int'(it.pos_y);
		pz = int'(it.pos_z);
		if (it.func == FUNC_WRITE) begin
			if (in_grid(px, py, pz))
				voxel_mem[vox_addr(px, py, pz)] = it.sample_in;
		end else begin
			r = '0;
			if (!in_grid(px, py, pz)) begin
				r.out_of_range = 1'b1;
			end else begin
				sum = 0;
				for (int c = -1; c <= 1; c++)
					for (int b = -1; b <= 1; b++)
						for (int a = -1; a <= 1; a++)
							sum += int'(voxel_mem[vox_addr(clamp_nb(px, a, nx),
								clamp_nb(py, b, ny), clamp_nb(pz, c, nz))]);
				r.blurred = SAMPLE_W'(sum / TAPS);
			end
			blur_expect_q.push_back(r);
		end
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(7))
			0: return 16'd0;
			1: return 16'd32768;
			2: return 16'hFFFF;
			3, 4: return SAMPLE_W'($urandom_range(32768));
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(9))
			0: return 6'd1;
			1: return 6'd2;
			2, 3, 4: return SIZE_W'($urandom_range(3, 6));
			5: return SIZE_W'($urandom_range(1, 12));
			6: return 6'd32;
			7: return SIZE_W'($urandom_range(33, 63));
			8: return 6'd0;
			default: return SIZE_W'($urandom_range(1, 31));
		endcase
	endfunction

	function automatic int near(input int c, input int n);
		int p;
		p = c + int'($urandom_range(4)) - 2;
		if (p < 0)
			p = 0;
		if (p > n - 1)
			p = n - 1;
		return p;
	endfunction

	function automatic void push_write(input int x, input int y, input int z,
		input logic [SAMPLE_W-1:0] v);
		item_t it;
		it.func      = FUNC_WRITE;
		it.pos_x     = COORD_W'(x);
		it.pos_y     = COORD_W'(y);
		it.pos_z     = COORD_W'(z);
		it.sample_in = v;
		if (in_grid(x, y, z)) begin
			voxel_filled[vox_addr(x, y, z)] = 1'b1;
			items_planned++;
		end
		item_pending_q.push_back(it);
	endfunction

	function automatic void push_query(input int x, input int y, input int z);
		item_t it;
		it.func      = FUNC_QUERY;
		it.pos_x     = COORD_W'(x);
		it.pos_y     = COORD_W'(y);
		it.pos_z     = COORD_W'(z);
		it.sample_in = SAMPLE_W'($urandom);
		items_planned++;
		item_pending_q.push_back(it);
	endfunction

	task automatic settle();
		@(posedge clk);
		while (item_pending_q.size() != 0 || item_valid || blur_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SIZE_X: size_x_reg = val;
			CFG_SIZE_Y: size_y_reg = val;
			CFG_SIZE_Z: size_z_reg = val;
			default: ;
		endcase
	endtask

	task automatic set_sizes(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
		input logic [SIZE_W-1:0] sz);
		settle();
		write_reg(CFG_SIZE_X, sx);
		write_reg(CFG_SIZE_Y, sy);
		write_reg(CFG_SIZE_Z, sz);
	endtask

	// mostly: fill a neighborhood, then query around it; the rest is noise
	task automatic random_phase(input int target);
		int start, k, nx, ny, nz, cx, cy, cz, x, y, z, n;
		nx = eff_size(size_x_reg);
		ny = eff_size(size_y_reg);
		nz = eff_size(size_z_reg);
		start = items_planned;
		while (items_planned - start < target) begin
			k = $urandom_range(99);
			if (k < 70 && nx > 0 && ny > 0 && nz > 0) begin
				cx = $urandom_range(nx - 1);
				cy = $urandom_range(ny - 1);
				cz = $urandom_range(nz - 1);
				for (int c = -1; c <= 1; c++)
					for (int b = -1; b <= 1; b++)
						for (int a = -1; a <= 1; a++) begin
							x = clamp_nb(cx, a, nx);
							y = clamp_nb(cy, b, ny);
							z = clamp_nb(cz, c, nz);
							if (!voxel_filled[vox_addr(x, y, z)] || $urandom_range(5) == 0)
								push_write(x, y, z, rand_sample());
						end
				n = $urandom_range(1, 4);
				repeat (n) begin
					x = near(cx, nx);
					y = near(cy, ny);
					z = near(cz, nz);
					if (neighborhood_filled(x, y, z))
						push_query(x, y, z);
				end
			end else if (k < 85) begin
				x = $urandom_range(31);
				y = $urandom_range(31);
				z = $urandom_range(31);
				if (!in_grid(x, y, z) || neighborhood_filled(x, y, z))
					push_query(x, y, z);
				else
					push_write(x, y, z, rand_sample());
			end else begin
				push_write($urandom_range(31), $urandom_range(31), $urandom_range(31),
					rand_sample());
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_ready) begin
			if (item_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item_valid <= 1'b1;
				item       <= item_pending_q.pop_front();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (stall_go && !stall_done) begin
			if (hold_cnt < LONG_HOLD) begin
				result_ready <= 1'b0;
				hold_cnt++;
			end else begin
				stall_done   <= 1'b1;
				result_ready <= 1'b1;
			end
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				predict_blur(item);
			if (result_valid && result_ready) begin
				if (blur_expect_q.size() == 0) begin
					$error("result transaction with nothing expected: blurred %0d, out_of_range %0d",
						result.blurred, result.out_of_range);
					mismatches++;
				end else begin
					want = blur_expect_q.pop_front();
					if (result.blurred !== want.blurred) begin
						$error("blurred: expected %0d, actual %0d", want.blurred, result.blurred);
						mismatches++;
					end
					if (result.out_of_range !== want.out_of_range) begin
						$error("out_of_range: expected %0d, actual %0d", want.out_of_range,
							result.out_of_range);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		logic [SAMPLE_W-1:0] corner_vals [8];
		int i;
		corner_vals = '{16'd0, 16'd32768, 16'hFFFF, 16'd1, 16'h5555, 16'hAAAA,
			16'd12345, 16'd32767};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset sizes: both far corners
		i = 0;
		for (int z = 0; z < 2; z++)
			for (int y = 0; y < 2; y++)
				for (int x = 0; x < 2; x++) begin
					push_write(x, y, z, corner_vals[i]);
					i++;
				end
		push_query(0, 0, 0);
		for (int z = 30; z < 32; z++)
			for (int y = 30; y < 32; y++)
				for (int x = 30; x < 32; x++)
					push_write(x, y, z, 16'hFFFF);
		push_query(31, 31, 31);

		// small grid: ignored write, queries inside and outside
		set_sizes(6'd2, 6'd2, 6'd2);
		push_write(31, 31, 31, 16'd0);
		push_query(1, 1, 1);
		push_query(2, 0, 0);
		push_query(31, 31, 31);

		// sizes saturate; unused index
		set_sizes(6'd63, 6'd63, 6'd63);
		write_reg(2'd3, 6'h2A);
		push_query(31, 31, 31);

		// empty grid
		set_sizes(6'd0, 6'd5, 6'd5);
		push_write(0, 0, 0, 16'd999);
		push_query(0, 0, 0);

		// single voxel grid
		set_sizes(6'd1, 6'd1, 6'd1);
		push_write(0, 0, 0, 16'd777);
		push_query(0, 0, 0);
		push_query(0, 1, 0);

		for (int phase = 0; phase < 8; phase++) begin
			set_sizes(pick_size(), pick_size(), pick_size());
			if (phase < 3) begin
				send_idle_pct = 10;
				recv_idle_pct = 63;
			end else if (phase < 6) begin
				send_idle_pct = 63;
				recv_idle_pct = 10;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			random_phase(140);
			if (phase == 6)
				stall_go = 1'b1;
		end

		settle();
		if (blur_expect_q.size() != 0)
			$error("%0d expected results never arrived", blur_expect_q.size());
		if (mismatches == 0 && blur_expect_q.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#5000000;
		$display("testbench: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/vbb_pkg.sv
src/vbb_div27.sv
src/volume_box_blur_clamped_top.sv
tb/testbench.sv
